// File: sv/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared constants, types and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;

  localparam int IN_W     = 16;
  localparam int ANG_W    = 24;
  localparam int ACC_W    = 16;
  localparam int WGT_W    = 17;
  localparam int CPD_W    = 16;
  localparam int CFG_W    = 17;

  localparam int SQ_W     = 32;
  localparam int RAD_W    = 2 * SQ_W;
  localparam int SQR_W    = SQ_W + 3;
  localparam int CX_W     = 36;
  localparam int Z_W      = 25;
  localparam int PROD_W   = 2 * IN_W;
  localparam int DEN_W    = 26;
  localparam int DIV_W    = PROD_W + ANGLE_FRAC_BITS + 1;
  localparam int GSUM_W   = DIV_W + 2;
  localparam int P1_W     = WGT_W + 1 + ANG_W;
  localparam int P2_W     = WGT_W + 1 + ACC_W;
  localparam int BSUM_W   = P1_W + 2;
  localparam int CNT_W    = 6;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(65536);
  localparam int ACC_LIM  = 90 * (2 ** ANGLE_FRAC_BITS);
  localparam int ANG_MAX  = 8388607;
  localparam int ANG_MIN  = -8388608;

  typedef enum logic {
    REG_GYRO_WEIGHT = 1'b0,
    REG_COUNTS_PER_DPS = 1'b1
  } cfg_reg_t;

  function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = Z_W'(2949120);
      5'd1:  v = Z_W'(1740967);
      5'd2:  v = Z_W'(919879);
      5'd3:  v = Z_W'(466945);
      5'd4:  v = Z_W'(234379);
      5'd5:  v = Z_W'(117304);
      5'd6:  v = Z_W'(58666);
      5'd7:  v = Z_W'(29335);
      5'd8:  v = Z_W'(14668);
      5'd9:  v = Z_W'(7334);
      5'd10: v = Z_W'(3667);
      5'd11: v = Z_W'(1833);
      5'd12: v = Z_W'(917);
      5'd13: v = Z_W'(458);
      5'd14: v = Z_W'(229);
      5'd15: v = Z_W'(115);
      5'd16: v = Z_W'(57);
      5'd17: v = Z_W'(29);
      5'd18: v = Z_W'(14);
      5'd19: v = Z_W'(7);
      5'd20: v = Z_W'(4);
      5'd21: v = Z_W'(2);
      5'd22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/ctf_if.sv
// ----------------------------------------------------------------------------
// ctf_in_if / ctf_out_if
// Valid/ready channels carrying sensor beats in and angle beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctf_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       accel_x;
  logic signed [15:0]       accel_y;
  logic signed [15:0]       accel_z;
  logic signed [15:0]       rate_x;
  logic        [15:0]       elapsed_ms;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, elapsed_ms,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, elapsed_ms,
                output ready);
endinterface

interface ctf_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [23:0]       fused_angle;
  logic signed [23:0]       gyro_angle;
  logic signed [15:0]       accel_angle;
  modport source (output valid, fused_angle, gyro_angle, accel_angle,
                  input ready);
  modport sink (input valid, fused_angle, gyro_angle, accel_angle,
                output ready);
endinterface

`default_nettype wire

// File: sv/complementary_tilt_filter_core.sv
// ----------------------------------------------------------------------------
// complementary_tilt_filter_core
// Fuses an accelerometer tilt angle with an integrated gyro rate.
// ----------------------------------------------------------------------------
// One sensor beat enters on in_ch when ready is high; one angle beat leaves on
// out_ch for each. The block works on one beat at a time. The accelerometer
// magnitude comes from a square root that resolves two radicand bits per
// cycle, followed by an iterative CORDIC. The gyro increment is divided out
// one quotient bit per cycle alongside. An accepted item passes the states
// LOAD1, LOAD2, SQRT, CORD, GYRO (which waits for the divider), MUL and FIN,
// where the result register is loaded; the next beat is taken once the
// result is loaded. The result register holds its beat while the receiver
// stalls; a following item is computed but waits for that register to empty
// before it finishes. Reset clears the stored angle to zero and loads the
// default weight and sensitivity. Configuration writes land on cfg_we and
// must come while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module complementary_tilt_filter_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ctf_in_if.sink                           in_ch,
  ctf_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ctf_pkg::CFG_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    IDLE, LOAD1, LOAD2, SQRT, CORD, GYRO, MUL, FIN
  } state_t;

  state_t state;
  logic [ctf_pkg::CNT_W-1:0] cnt;

  logic [ctf_pkg::WGT_W-1:0] gyro_weight;
  logic [ctf_pkg::CPD_W-1:0] counts_per_dps;
  logic signed [ctf_pkg::ANG_W-1:0] previous_angle;

  logic signed [ctf_pkg::IN_W-1:0] ax, ay, az, rate;
  logic [ctf_pkg::IN_W-1:0] ms;
  logic ay_zero;

  logic [ctf_pkg::PROD_W-1:0] sq_x, sq_z;
  logic signed [ctf_pkg::PROD_W-1:0] prod;
  logic [ctf_pkg::DEN_W-1:0] den;

  logic [ctf_pkg::RAD_W-1:0] sq_rad;
  logic [ctf_pkg::SQR_W-1:0] sq_rem;
  logic [ctf_pkg::SQ_W-1:0] sq_root;
  logic [ctf_pkg::SQR_W-1:0] sq_t, sq_try;

  logic signed [ctf_pkg::CX_W-1:0] cx, cy;
  logic signed [ctf_pkg::Z_W-1:0] cz;

  logic div_busy, div_neg;
  logic [ctf_pkg::CNT_W-1:0] div_cnt;
  logic [ctf_pkg::DIV_W-1:0] dv_dvd;
  logic [ctf_pkg::DEN_W-1:0] dv_rem;
  logic [ctf_pkg::DEN_W:0] dv_t;

  logic signed [ctf_pkg::ANG_W-1:0] gyro;
  logic signed [ctf_pkg::ACC_W-1:0] acc;
  logic signed [ctf_pkg::P1_W-1:0] p1;
  logic signed [ctf_pkg::P2_W-1:0] p2;
  logic [ctf_pkg::WGT_W-1:0] w_eff;

  logic [ctf_pkg::PROD_W-1:0] prod_mag;
  logic signed [ctf_pkg::Z_W-1:0] z_rnd;
  logic signed [ctf_pkg::GSUM_W-1:0] g_sum, q_s;
  logic signed [ctf_pkg::BSUM_W-1:0] b_sum, b_shf;
  logic signed [ctf_pkg::ANG_W-1:0] gyro_sat, fused_sat;
  logic signed [ctf_pkg::ACC_W-1:0] acc_sat;

  assign in_ch.ready = (state == IDLE);

  always_comb begin
    w_eff = (gyro_weight > ctf_pkg::WGT_ONE) ? ctf_pkg::WGT_ONE : gyro_weight;
    sq_t = {sq_rem[ctf_pkg::SQR_W-3:0], sq_rad[ctf_pkg::RAD_W-1 -: 2]};
    sq_try = {1'b0, sq_root, 2'b01};
    dv_t = {dv_rem, dv_dvd[ctf_pkg::DIV_W-1]};
    prod_mag = prod[ctf_pkg::PROD_W-1] ? ctf_pkg::PROD_W'(-prod)
                                       : ctf_pkg::PROD_W'(prod);
    z_rnd = (cz + ctf_pkg::Z_W'(2 ** (15 - ctf_pkg::ANGLE_FRAC_BITS)))
            >>> (16 - ctf_pkg::ANGLE_FRAC_BITS);
    q_s = div_neg ? -ctf_pkg::GSUM_W'(dv_dvd) : ctf_pkg::GSUM_W'(dv_dvd);
    g_sum = ctf_pkg::GSUM_W'(previous_angle) + q_s;
    priority if (g_sum > ctf_pkg::GSUM_W'(ctf_pkg::ANG_MAX)) begin
      gyro_sat = ctf_pkg::ANG_W'(ctf_pkg::ANG_MAX);
    end else if (g_sum < ctf_pkg::GSUM_W'(ctf_pkg::ANG_MIN)) begin
      gyro_sat = ctf_pkg::ANG_W'(ctf_pkg::ANG_MIN);
    end else begin
      gyro_sat = ctf_pkg::ANG_W'(g_sum);
    end
    priority if (ay_zero) begin
      acc_sat = '0;
    end else if (z_rnd > ctf_pkg::Z_W'(ctf_pkg::ACC_LIM)) begin
      acc_sat = ctf_pkg::ACC_W'(ctf_pkg::ACC_LIM > 32767 ? 32767 : ctf_pkg::ACC_LIM);
    end else if (z_rnd < -ctf_pkg::Z_W'(ctf_pkg::ACC_LIM)) begin
      acc_sat = ctf_pkg::ACC_W'(ctf_pkg::ACC_LIM > 32768 ? -32768 : -ctf_pkg::ACC_LIM);
    end else begin
      acc_sat = ctf_pkg::ACC_W'(z_rnd);
    end
    b_sum = ctf_pkg::BSUM_W'(p1) + ctf_pkg::BSUM_W'(p2) + ctf_pkg::BSUM_W'(32768);
    b_shf = b_sum >>> 16;
    priority if (b_shf > ctf_pkg::BSUM_W'(ctf_pkg::ANG_MAX)) begin
      fused_sat = ctf_pkg::ANG_W'(ctf_pkg::ANG_MAX);
    end else if (b_shf < ctf_pkg::BSUM_W'(ctf_pkg::ANG_MIN)) begin
      fused_sat = ctf_pkg::ANG_W'(ctf_pkg::ANG_MIN);
    end else begin
      fused_sat = ctf_pkg::ANG_W'(b_shf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      div_busy <= 1'b0;
      div_cnt <= '0;
      out_ch.valid <= 1'b0;
      previous_angle <= '0;
      gyro_weight <= ctf_pkg::WGT_W'(62259);
      counts_per_dps <= ctf_pkg::CPD_W'(131);
    end else begin
      if (cfg_we) begin
        unique case (ctf_pkg::cfg_reg_t'(cfg_index))
          ctf_pkg::REG_GYRO_WEIGHT: gyro_weight <= cfg_data;
          ctf_pkg::REG_COUNTS_PER_DPS: counts_per_dps <= cfg_data[ctf_pkg::CPD_W-1:0];
        endcase
      end
      if (out_ch.valid && out_ch.ready && state != FIN) begin
        out_ch.valid <= 1'b0;
      end
      if (div_busy) begin
        if (dv_t >= {1'b0, den}) begin
          dv_rem <= ctf_pkg::DEN_W'(dv_t - {1'b0, den});
          dv_dvd <= {dv_dvd[ctf_pkg::DIV_W-2:0], 1'b1};
        end else begin
          dv_rem <= ctf_pkg::DEN_W'(dv_t);
          dv_dvd <= {dv_dvd[ctf_pkg::DIV_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == ctf_pkg::CNT_W'(ctf_pkg::DIV_W - 1)) begin
          div_busy <= 1'b0;
        end
      end
      unique case (state)
        IDLE: begin
          if (in_ch.valid) begin
            ax <= in_ch.accel_x;
            ay <= in_ch.accel_y;
            az <= in_ch.accel_z;
            rate <= in_ch.rate_x;
            ms <= in_ch.elapsed_ms;
            state <= LOAD1;
          end
        end
        LOAD1: begin
          sq_x <= ctf_pkg::PROD_W'(ax * ax);
          sq_z <= ctf_pkg::PROD_W'(az * az);
          prod <= ctf_pkg::PROD_W'(rate * $signed({1'b0, ms}));
          den <= ctf_pkg::DEN_W'(((counts_per_dps == '0) ? ctf_pkg::CPD_W'(1)
                                                          : counts_per_dps) * 10'd1000);
          ay_zero <= (ay == '0);
          state <= LOAD2;
        end
        LOAD2: begin
          sq_rad <= {sq_x + sq_z, ctf_pkg::SQ_W'(0)};
          sq_rem <= '0;
          sq_root <= '0;
          div_neg <= prod[ctf_pkg::PROD_W-1];
          dv_dvd <= ctf_pkg::DIV_W'({prod_mag, ctf_pkg::ANGLE_FRAC_BITS'(0)})
                    + ctf_pkg::DIV_W'(den >> 1);
          dv_rem <= '0;
          div_cnt <= '0;
          div_busy <= 1'b1;
          cnt <= '0;
          state <= SQRT;
        end
        SQRT: begin
          sq_rad <= {sq_rad[ctf_pkg::RAD_W-3:0], 2'b00};
          if (sq_t >= sq_try) begin
            sq_rem <= sq_t - sq_try;
            sq_root <= {sq_root[ctf_pkg::SQ_W-2:0], 1'b1};
          end else begin
            sq_rem <= sq_t;
            sq_root <= {sq_root[ctf_pkg::SQ_W-2:0], 1'b0};
          end
          if (cnt == ctf_pkg::CNT_W'(ctf_pkg::SQ_W - 1)) begin
            cnt <= '0;
            state <= CORD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        CORD: begin
          cnt <= cnt + 1'b1;
          if (cnt == ctf_pkg::CNT_W'(ctf_pkg::CORDIC_STEPS)) begin
            state <= GYRO;
          end
        end
        GYRO: begin
          if (!div_busy) begin
            gyro <= gyro_sat;
            acc <= acc_sat;
            state <= MUL;
          end
        end
        MUL: begin
          p1 <= ctf_pkg::P1_W'($signed({1'b0, w_eff}) * gyro);
          p2 <= ctf_pkg::P2_W'($signed({1'b0, ctf_pkg::WGT_W'(ctf_pkg::WGT_ONE - w_eff)})
                               * acc);
          state <= FIN;
        end
        FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.fused_angle <= fused_sat;
            out_ch.gyro_angle <= gyro;
            out_ch.accel_angle <= acc;
            previous_angle <= fused_sat;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (state == CORD) begin
        if (cnt == '0) begin
          cx <= ctf_pkg::CX_W'(sq_root);
          cy <= -(ctf_pkg::CX_W'(ay) <<< 16);
          cz <= '0;
        end else if (!cy[ctf_pkg::CX_W-1]) begin
          cx <= cx + (cy >>> (cnt[4:0] - 1'b1));
          cy <= cy - (cx >>> (cnt[4:0] - 1'b1));
          cz <= cz + ctf_pkg::atan_deg(cnt[4:0] - 1'b1);
        end else begin
          cx <= cx - (cy >>> (cnt[4:0] - 1'b1));
          cy <= cy + (cx >>> (cnt[4:0] - 1'b1));
          cz <= cz - ctf_pkg::atan_deg(cnt[4:0] - 1'b1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ctf_checker.sv
// ----------------------------------------------------------------------------
// ctf_checker
// Port-level checks of the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] accel_angle,
  input wire logic signed [23:0] gyro_angle
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gyro_angle))
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_accel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accel_angle <= 16'sd23040 && accel_angle >= -16'sd23040)
    else $error("accel angle out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind complementary_tilt_filter_core ctf_checker u_ctf_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .accel_angle(out_ch.accel_angle), .gyro_angle(out_ch.gyro_angle)
);

`default_nettype wire
